>>> rtl/core/preferential_attachment_select_assert.svh
// Assertion macros used by the block's sequencer module.
`ifndef PREFERENTIAL_ATTACHMENT_SELECT_ASSERT_SVH
`define PREFERENTIAL_ATTACHMENT_SELECT_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PAS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PAS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/pas_pkg.sv
package pas_pkg;

   localparam int MAX_NODES = 256;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = NODE_W + 1;
   localparam int DEG_W     = 8;
   localparam int SUM_W     = 16;
   localparam int RAND_W    = 20;
   localparam int PROD_W    = RAND_W + SUM_W;
   localparam int ROW_W     = MAX_NODES;

   localparam logic [PROD_W-1:0] SCALE    = PROD_W'(1000000);
   localparam logic [RAND_W-1:0] DRAW_MAX = RAND_W'(999999);

   localparam logic MODE_SEED   = 1'b0;
   localparam logic MODE_ATTACH = 1'b1;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_ZERO    = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_IGNORED = 2'd3
   } status_type;

   typedef struct packed {
      logic              mode;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [RAND_W-1:0] random_value;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [NODE_W-1:0] chosen_node;
      logic [NODE_W-1:0] new_node;
      logic [CNT_W-1:0]  node_total;
   } res_type;

endpackage

>>> rtl/core/pas_ram.sv
module pas_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/pas_seq.sv
`include "preferential_attachment_select_assert.svh"

module pas_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [pas_pkg::CNT_W-1:0] start_nodes,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pas_pkg::req_type          req,
   output logic                      res_valid,
   input  logic                      res_ready,
   output pas_pkg::res_type          res
);
   import pas_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SUM, ST_MUL, ST_PICK,
      ST_EDGE_RD, ST_EDGE_A, ST_EDGE_B, ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [NODE_W-1:0] a_ff, a_in;
   logic [NODE_W-1:0] b_ff, b_in;
   logic              att_ff, att_in;
   logic [RAND_W-1:0] r_ff, r_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] tgt_ff, tgt_in;
   logic [PROD_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              pend_ff, pend_in;
   logic [NODE_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0]  added_ff, added_in;
   status_type        status_ff, status_in;
   logic [NODE_W-1:0] chosen_ff, chosen_in;
   logic [NODE_W-1:0] fresh_ff, fresh_in;

   logic              adj_we, deg_we;
   logic [NODE_W-1:0] adj_waddr, adj_raddr, deg_waddr, deg_raddr;
   logic [ROW_W-1:0]  adj_wdata, adj_q;
   logic [DEG_W-1:0]  deg_wdata, deg_q;

   logic [CNT_W-1:0]  s_clamp, n;
   logic [CNT_W:0]    n_sum;
   logic              issue;
   logic [PROD_W-1:0] hi;

   pas_ram #(.WIDTH(ROW_W), .ADDR_W(NODE_W)) u_adj (
      .clock (clock),
      .we    (adj_we),
      .waddr (adj_waddr),
      .wdata (adj_wdata),
      .raddr (adj_raddr),
      .rdata (adj_q)
   );

   pas_ram #(.WIDTH(DEG_W), .ADDR_W(NODE_W)) u_deg (
      .clock (clock),
      .we    (deg_we),
      .waddr (deg_waddr),
      .wdata (deg_wdata),
      .raddr (deg_raddr),
      .rdata (deg_q)
   );

   always_comb begin
      if (start_nodes == '0) begin
         s_clamp = CNT_W'(1);
      end else if (start_nodes > CNT_W'(MAX_NODES)) begin
         s_clamp = CNT_W'(MAX_NODES);
      end else begin
         s_clamp = start_nodes;
      end
      n_sum = {1'b0, s_clamp} + {1'b0, added_ff};
      if (n_sum > (CNT_W + 1)'(MAX_NODES)) begin
         n = CNT_W'(MAX_NODES);
      end else begin
         n = n_sum[CNT_W-1:0];
      end
   end

   assign issue = (iss_ff < n);
   assign hi    = lo_ff + (PROD_W'(deg_q) * SCALE);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      att_in    = att_ff;
      r_in      = r_ff;
      sum_in    = sum_ff;
      tgt_in    = tgt_ff;
      lo_in     = lo_ff;
      iss_in    = iss_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      added_in  = added_ff;
      status_in = status_ff;
      chosen_in = chosen_ff;
      fresh_in  = fresh_ff;
      adj_we    = 1'b0;
      deg_we    = 1'b0;
      adj_waddr = a_ff;
      deg_waddr = a_ff;
      adj_wdata = adj_q | (ROW_W'(1) << b_ff);
      deg_wdata = deg_q + DEG_W'(1);
      adj_raddr = a_ff;
      deg_raddr = iss_ff[NODE_W-1:0];
      req_ready = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            adj_we    = 1'b1;
            deg_we    = 1'b1;
            adj_waddr = clr_ff;
            deg_waddr = clr_ff;
            adj_wdata = '0;
            deg_wdata = '0;
            clr_in    = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               a_in      = req.node_a;
               b_in      = req.node_b;
               att_in    = (req.mode == MODE_ATTACH);
               r_in      = (req.random_value > DRAW_MAX) ? DRAW_MAX : req.random_value;
               chosen_in = '0;
               fresh_in  = '0;
               status_in = STAT_DONE;
               iss_in    = '0;
               pend_in   = 1'b0;
               sum_in    = '0;
               if (req.mode == MODE_ATTACH) begin
                  state_in = ST_SUM;
               end else if ((CNT_W'(req.node_a) >= n) || (CNT_W'(req.node_b) >= n) ||
                            (req.node_a == req.node_b)) begin
                  status_in = STAT_IGNORED;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_EDGE_RD;
               end
            end
         end
         ST_SUM: begin
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(deg_q);
            end
            iss_in  = issue ? iss_ff + CNT_W'(1) : iss_ff;
            pend_in = issue;
            if (!issue && !pend_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            iss_in  = '0;
            pend_in = 1'b0;
            lo_in   = '0;
            tgt_in  = PROD_W'(r_ff) * PROD_W'(sum_ff);
            if (sum_ff == '0) begin
               status_in = STAT_ZERO;
               state_in  = ST_DONE;
            end else if (n == CNT_W'(MAX_NODES)) begin
               status_in = STAT_FULL;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (pend_ff && (tgt_ff <= hi)) begin
               a_in     = pidx_ff;
               b_in     = n[NODE_W-1:0];
               pend_in  = 1'b0;
               state_in = ST_EDGE_RD;
            end else begin
               if (pend_ff) begin
                  lo_in = hi;
               end
               iss_in  = issue ? iss_ff + CNT_W'(1) : iss_ff;
               pend_in = issue;
               pidx_in = iss_ff[NODE_W-1:0];
               if (!issue && !pend_ff) begin
                  a_in     = NODE_W'(n - CNT_W'(1));
                  b_in     = n[NODE_W-1:0];
                  state_in = ST_EDGE_RD;
               end
            end
         end
         ST_EDGE_RD: begin
            deg_raddr = a_ff;
            state_in  = ST_EDGE_A;
         end
         ST_EDGE_A: begin
            adj_raddr = b_ff;
            deg_raddr = b_ff;
            if (att_ff) begin
               added_in  = added_ff + CNT_W'(1);
               status_in = STAT_DONE;
               chosen_in = a_ff;
               fresh_in  = b_ff;
            end else begin
               status_in = adj_q[b_ff] ? STAT_IGNORED : STAT_DONE;
            end
            if (adj_q[b_ff]) begin
               state_in = ST_DONE;
            end else begin
               adj_we   = 1'b1;
               deg_we   = 1'b1;
               state_in = ST_EDGE_B;
            end
         end
         ST_EDGE_B: begin
            adj_we    = 1'b1;
            deg_we    = 1'b1;
            adj_waddr = b_ff;
            deg_waddr = b_ff;
            adj_wdata = adj_q | (ROW_W'(1) << a_ff);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.status      = status_ff;
      res.chosen_node = chosen_ff;
      res.new_node    = fresh_ff;
      res.node_total  = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         added_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
         added_ff <= added_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      att_ff    <= att_in;
      r_ff      <= r_in;
      sum_ff    <= sum_in;
      tgt_ff    <= tgt_in;
      lo_ff     <= lo_in;
      iss_ff    <= iss_in;
      pidx_ff   <= pidx_in;
      status_ff <= status_in;
      chosen_ff <= chosen_in;
      fresh_ff  <= fresh_in;
   end

   `PAS_ASSERT_IMPLIES(a_walk_no_write, clock, reset,
      (state_ff == ST_SUM) || (state_ff == ST_PICK), !adj_we && !deg_we,
      "memory written during degree walk")
   `PAS_ASSERT_IMPLIES(a_walk_in_range, clock, reset,
      (state_ff == ST_SUM) || (state_ff == ST_PICK), iss_ff <= n,
      "walk address beyond present nodes")
   `PAS_ASSERT_IMPLIES(a_edge_distinct, clock, reset,
      (state_ff == ST_EDGE_A) || (state_ff == ST_EDGE_B), a_ff != b_ff,
      "edge update with equal endpoints")
   `PAS_ASSERT_IMPLIES(a_ready_idle, clock, reset,
      req_ready, !res_valid && !adj_we,
      "request taken while an item is in flight")

endmodule

>>> rtl/core/preferential_attachment_select.sv
// Channel   Direction  Fields (tdata / tuser)
// req_      in         tdata: node_a, node_b, random_value; tuser: mode
// rsp_      out        tdata: chosen_node, new_node, node_total; tuser: status
// csr_      in         wdata: start_nodes
//
// One item is in work at a time. An attach makes two walks over the degree memory of
// the n present nodes, one node read per cycle (sum, then roulette pick).
// After reset a clearing pass zeroes all 256 entries of both memories; req_tready stays low.
// The result register frees the sequencer: a new item is taken while a result waits.
module preferential_attachment_select (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // node_a[7:0], node_b[15:8], random_value[35:16], zero
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // chosen_node[7:0], new_node[15:8], node_total[24:16], zero
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata    // start_nodes
);
   import pas_pkg::*;

   logic [CNT_W-1:0] start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff, rsp_in;
   req_type          req;
   res_type          res;
   logic             res_valid, res_ready;

   always_comb begin
      req.mode         = req_tuser;
      req.node_a       = req_tdata[7:0];
      req.node_b       = req_tdata[15:8];
      req.random_value = req_tdata[35:16];
   end

   pas_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start_nodes (start_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      start_in     = csr_we ? csr_wdata : start_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {7'd0, rsp_ff.node_total, rsp_ff.new_node, rsp_ff.chosen_node};

endmodule
